// ===== design/fem_pkg.sv =====
// fem_pkg: shared types, codes and helpers of the frontier edge marker
// no dependencies; used by fem_div, frontier_edge_marker, edge_marker_checker and tb

package fem_pkg;

	localparam int IDX_W = 16;
	localparam int DIM_W = 9;
	localparam int CELL_W = 8;

	localparam logic [1:0] OP_WRITE   = 2'd0;
	localparam logic [1:0] OP_EXAMINE = 2'd1;
	localparam logic [1:0] OP_READ    = 2'd2;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic [CELL_W-1:0] MARK_VALUE    = 8'd10;
	localparam logic [CELL_W-1:0] UNKNOWN_VALUE = 8'hFF;
	localparam logic [CELL_W-1:0] FREE_VALUE    = 8'd0;

	localparam logic [DIM_W-1:0] DIM_MIN = 9'd3;
	localparam logic [DIM_W-1:0] DIM_MAX = 9'd256;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_READ,
		ST_READ_WAIT,
		ST_DIV,
		ST_SCAN,
		ST_EMIT,
		ST_NONE
	} fem_state_t;

	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [DIM_W-1:0] col;
	} div_res_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v < DIM_MIN) r = DIM_MIN;
		if (v > DIM_MAX) r = DIM_MAX;
		return r;
	endfunction

	// lowest set bit of the pending mark mask
	function automatic logic [2:0] first_set(input logic [7:0] m);
		logic [2:0] r;
		r = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (m[i]) r = 3'(i);
		end
		return r;
	endfunction

	// neighbour k: below-left, below, below-right, left, right, above-left, above, above-right
	function automatic logic [IDX_W:0] nb_addr(input logic [IDX_W-1:0] idx,
			input logic [DIM_W-1:0] w, input logic [2:0] k);
		logic [IDX_W+1:0] base;
		logic [IDX_W+1:0] roff;
		logic [IDX_W+1:0] coff;
		base = {2'b00, idx};
		case (k)
			3'd0, 3'd1, 3'd2: roff = -{9'd0, w};
			3'd5, 3'd6, 3'd7: roff = {9'd0, w};
			default: roff = '0;
		endcase
		case (k)
			3'd0, 3'd3, 3'd5: coff = '1;
			3'd2, 3'd4, 3'd7: coff = 18'd1;
			default: coff = '0;
		endcase
		return 17'(base + roff + coff);
	endfunction

endpackage

// ===== design/fem_div.sv =====
// fem_div: radix-2 restoring divider, one quotient bit per cycle
// splits a raster index into row and column; uses fem_pkg

module fem_div
	import fem_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [IDX_W-1:0] dividend,
	input  logic [DIM_W-1:0] divisor,
	output logic             done,
	output div_res_t         res
);

	logic             busy_q;
	logic             done_q;
	logic [3:0]       cnt_q;
	logic [IDX_W-1:0] quot_q;
	logic [DIM_W-1:0] rem_q;
	logic [DIM_W-1:0] div_q;
	logic [DIM_W:0]   trial;
	logic             take;

	assign trial = {rem_q, quot_q[IDX_W-1]};
	assign take  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			div_q  <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[IDX_W-2:0], take};
			rem_q  <= take ? DIM_W'(trial - {1'b0, div_q}) : DIM_W'(trial);
		end
	end

	assign done    = done_q;
	assign res.row = quot_q;
	assign res.col = rem_q;

endmodule

// ===== design/fem_ram.sv =====
// fem_ram: single-port grid store, registered read data, no reset
// generic memory; no dependencies

module fem_ram #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16,
	parameter int DW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [DW-1:0] wdata,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end

endmodule

// ===== design/frontier_edge_marker.sv =====
// frontier_edge_marker: occupancy grid store with 8-neighbour frontier marking
// write: ST_WRITE stores the cell; read: ST_READ, then ST_READ_WAIT; other opcodes: ST_NONE;
// examine: ST_DIV waits on the divider that splits the index into row and column, ST_SCAN
// reads the single ram port; ST_EMIT pushes one to eight words, ST_NONE one when not interior
// one word in flight at a time; the output register frees the input side once filled
// arst_n clears control, edge counter and sizes (256 x 256); the grid store is not cleared

module frontier_edge_marker
	import fem_pkg::*;
#(
	parameter int MAX_CELLS = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // cell_index, cell_value
	input  logic [1:0]  s_tuser,   // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // edge_index, edge_number, read_value
	output logic        m_tuser,   // edge_found
	output logic        m_tlast
);

	localparam int AW = $clog2(MAX_CELLS);

	fem_state_t state_q, state_d;

	logic [DIM_W-1:0]  width_q, height_q;
	logic [DIM_W-1:0]  w, h;
	logic [1:0]        op_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CELL_W-1:0] val_q;
	logic [3:0]        cnt_q;
	logic [7:0]        mask_q;
	logic              centre_unk_q;
	logic [15:0]       edge_count_q;

	logic              out_valid_q;
	logic              out_found_q;
	logic [15:0]       out_idx_q;
	logic [15:0]       out_num_q;
	logic [CELL_W-1:0] out_rv_q;
	logic              out_last_q;

	logic              push, push_found, push_last;
	logic [15:0]       push_idx;
	logic [CELL_W-1:0] push_rv;
	logic              mark;

	logic              div_start, div_done;
	div_res_t          div_res;
	logic              row_ok, col_ok, fit_ok, in_range, can_push;
	logic [IDX_W:0]    far_idx, nb;
	logic [2:0]        sel, nb_k;
	logic [7:0]        rest;

	logic              ram_we;
	logic [AW-1:0]     ram_addr;
	logic [CELL_W-1:0] ram_wdata, ram_rdata;

	fem_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (s_tdata[15:0]),
		.divisor  (w),
		.done     (div_done),
		.res      (div_res)
	);

	fem_ram #(.DEPTH(MAX_CELLS), .AW(AW), .DW(CELL_W)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign w         = clamp_dim(width_q);
	assign h         = clamp_dim(height_q);
	assign s_tready  = state_q == ST_IDLE;
	assign div_start = s_tvalid && s_tready && s_tuser == OP_EXAMINE;
	assign can_push  = !out_valid_q || m_tready;
	assign in_range  = int'(idx_q) < MAX_CELLS;

	assign row_ok  = div_res.row != '0 && (17'(div_res.row) + 17'd2 <= 17'(h));
	assign col_ok  = div_res.col != '0 && (10'(div_res.col) + 10'd2 <= 10'(w));
	assign far_idx = 17'(idx_q) + 17'(w) + 17'd1;
	assign fit_ok  = int'(far_idx) < MAX_CELLS;

	assign sel  = first_set(mask_q);
	assign rest = mask_q & ~(8'd1 << sel);
	assign nb_k = (state_q == ST_SCAN) ? cnt_q[2:0] : sel;
	assign nb   = nb_addr(idx_q, w, nb_k);

	assign ram_wdata = (state_q == ST_EMIT) ? MARK_VALUE : val_q;

	always_comb begin
		state_d    = state_q;
		push       = 1'b0;
		push_found = 1'b0;
		push_idx   = '0;
		push_rv    = '0;
		push_last  = 1'b1;
		mark       = 1'b0;
		ram_we     = 1'b0;
		ram_addr   = AW'(idx_q);
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					case (s_tuser)
						OP_WRITE:   state_d = ST_WRITE;
						OP_EXAMINE: state_d = ST_DIV;
						OP_READ:    state_d = ST_READ;
						default:    state_d = ST_NONE;
					endcase
				end
			end
			ST_WRITE: begin
				if (can_push) begin
					ram_we  = in_range;
					push    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_READ: state_d = ST_READ_WAIT;
			ST_READ_WAIT: begin
				if (can_push) begin
					push    = 1'b1;
					push_rv = in_range ? ram_rdata : '0;
					state_d = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (div_done) state_d = (row_ok && col_ok && fit_ok) ? ST_SCAN : ST_NONE;
			end
			ST_SCAN: begin
				if (cnt_q != 4'd8) ram_addr = AW'(nb);
				else state_d = ST_EMIT;
			end
			ST_EMIT: begin
				ram_addr = AW'(nb);
				if (can_push) begin
					push = 1'b1;
					if (centre_unk_q && mask_q != '0) begin
						mark       = 1'b1;
						ram_we     = 1'b1;
						push_found = 1'b1;
						push_idx   = nb[15:0];
						push_last  = rest == '0;
						if (rest == '0) state_d = ST_IDLE;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_NONE: begin
				if (can_push) begin
					push    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q      <= DIM_MAX;
			height_q     <= DIM_MAX;
			edge_count_q <= '0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == REG_WIDTH) width_q <= cfg_data;
			if (cfg_we && cfg_index == REG_HEIGHT) height_q <= cfg_data;
			if (mark && edge_count_q != 16'hFFFF) edge_count_q <= edge_count_q + 16'd1;
			cnt_q <= (state_q == ST_SCAN) ? cnt_q + 4'd1 : '0;
			if (push) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q  <= s_tuser;
			idx_q <= s_tdata[15:0];
			val_q <= s_tdata[23:16];
		end
		if (state_q == ST_SCAN) begin
			if (cnt_q == 4'd0) begin
				centre_unk_q <= ram_rdata == UNKNOWN_VALUE;
				mask_q       <= '0;
			end else begin
				mask_q[3'(cnt_q - 4'd1)] <= ram_rdata == FREE_VALUE;
			end
		end else if (mark) begin
			mask_q <= rest;
		end
		if (push) begin
			out_found_q <= push_found;
			out_idx_q   <= push_idx;
			out_num_q   <= push_found ? edge_count_q : 16'd0;
			out_rv_q    <= push_rv;
			out_last_q  <= push_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_rv_q, out_num_q, out_idx_q};
	assign m_tuser  = out_found_q;
	assign m_tlast  = out_last_q;

	// edge counter moves by one at most
	assert property (@(posedge clk) disable iff (!arst_n)
		edge_count_q == $past(edge_count_q) || edge_count_q == $past(edge_count_q) + 16'd1)
		else $error("edge counter jumped");

	// grid store is written only by a write word or a mark
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_WRITE && op_q == OP_WRITE) || state_q == ST_EMIT)
		else $error("unexpected grid write");

	// a frontier edge word never carries a read value
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[39:32] == '0)
		else $error("edge word with read value");

endmodule

// ===== test/edge_marker_checker.sv =====
// edge_marker_checker: watches the config port and both streams of the frontier edge marker,
// keeps its own copy of the grid, sizes and edge counter, and compares every output word
// depends on fem_pkg for opcodes, register indexes and cell codes
`timescale 1ns / 1ps

module edge_marker_checker
	import fem_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,   // cell_index, cell_value
	input  logic [1:0]  s_tuser,   // opcode
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,   // edge_index, edge_number, read_value
	input  logic        m_tuser,   // edge_found
	input  logic        m_tlast,
	output int          fail_count,
	output int          words_owed
);

	typedef struct packed {
		logic        found;
		logic [15:0] nb_idx;
		logic [15:0] count;
		logic [7:0]  value;
		logic        last;
	} result_word_t;

	logic [7:0]   grid [0:65535];
	logic [8:0]   width_reg;
	logic [8:0]   height_reg;
	logic [15:0]  edges_seen;
	result_word_t owed [$];
	result_word_t head;

	function automatic int dim_of(input logic [8:0] v);
		if (v < 9'd3)
			return 3;
		if (v > 9'd256)
			return 256;
		return int'(v);
	endfunction

	// works out the words one accepted item causes and updates the grid copy
	task automatic predict_words(input logic [1:0] op, input logic [15:0] idx,
			input logic [7:0] val);
		int           w;
		int           h;
		int           row;
		int           col;
		int           centre;
		int           final_k;
		int           nb [8];
		logic [7:0]   hit;
		result_word_t r;
		r = '0;
		r.last = 1'b1;
		hit = '0;
		final_k = -1;
		case (op)
			OP_WRITE: begin
				grid[idx] = val;
				owed.push_back(r);
			end
			OP_READ: begin
				r.value = grid[idx];
				owed.push_back(r);
			end
			OP_EXAMINE: begin
				w = dim_of(width_reg);
				h = dim_of(height_reg);
				centre = int'(idx);
				row = centre / w;
				col = centre % w;
				if (row >= 1 && row + 2 <= h && col >= 1 && col + 2 <= w &&
						centre + w + 1 < 65536 && grid[idx] == UNKNOWN_VALUE) begin
					// ring order skips the centre of the 3x3 block, lower row first
					for (int k = 0; k < 8; k++) begin
						nb[k] = centre + ((k < 4 ? k : k + 1) / 3 - 1) * w +
							(k < 4 ? k : k + 1) % 3 - 1;
						hit[k] = (grid[nb[k]] == FREE_VALUE);
						if (hit[k])
							final_k = k;
					end
					for (int k = 0; k < 8; k++) begin
						if (hit[k]) begin
							grid[nb[k]] = MARK_VALUE;
							r.found = 1'b1;
							r.nb_idx = 16'(nb[k]);
							r.count = edges_seen;
							r.last = (k == final_k);
							owed.push_back(r);
							if (edges_seen != 16'hFFFF)
								edges_seen = edges_seen + 16'd1;
						end
					end
				end
				if (final_k < 0)
					owed.push_back(r);
			end
			default: owed.push_back(r);
		endcase
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = 9'd256;
			height_reg = 9'd256;
			edges_seen = '0;
			owed.delete();
			words_owed <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_WIDTH)
					width_reg = cfg_data;
				else
					height_reg = cfg_data;
			end
			if (m_tvalid && m_tready) begin
				if (owed.size() == 0) begin
					$display("%0t: unexpected word, expected none, actual %h %h %h", $time,
						m_tuser, m_tdata, m_tlast);
					fail_count++;
				end else begin
					head = owed.pop_front();
					check_field("edge_found", 16'(head.found), 16'(m_tuser));
					check_field("edge_index", head.nb_idx, m_tdata[15:0]);
					check_field("edge_number", head.count, m_tdata[31:16]);
					check_field("read_value", 16'(head.value), 16'(m_tdata[39:32]));
					check_field("last", 16'(head.last), 16'(m_tlast));
				end
			end
			if (s_tvalid && s_tready)
				predict_words(s_tuser, s_tdata[15:0], s_tdata[23:16]);
			words_owed <= int'(owed.size());
		end
	end

endmodule

// ===== test/tb.sv =====
// tb: drives the frontier edge marker with directed and random words under random stalls
// and several grid sizes; depends on fem_pkg, frontier_edge_marker and edge_marker_checker
`timescale 1ns / 1ps

module tb;
	import fem_pkg::*;

	localparam logic [1:0] OP_NOP = 2'd3;
	localparam int CYCLE_LIMIT = 1000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [8:0]  cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // cell_index, cell_value
	logic [1:0]  s_tuser = '0;   // opcode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // edge_index, edge_number, read_value
	logic        m_tuser;        // edge_found
	logic        m_tlast;
	int          fail_count;
	int          words_owed;

	bit          known [0:65535];
	int          known_list [$];
	int          cur_w = 256;
	int          cur_h = 256;
	bit          quiet = 1'b0;
	int          stall_left = 0;
	int          cycle_count = 0;
	int          phase_items = 0;

	frontier_edge_marker u_dut (.*);

	edge_marker_checker u_check (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pause_len();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 3) == 0) begin
			stall_left <= pause_len();
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic bit interior(input int idx);
		int row;
		int col;
		row = idx / cur_w;
		col = idx % cur_w;
		return row >= 1 && row + 2 <= cur_h && col >= 1 && col + 2 <= cur_w;
	endfunction

	// an interior examine reads the whole 3x3 block, so all of it must hold data
	function automatic bit area_known(input int idx);
		if (!known[idx])
			return 1'b0;
		if (!interior(idx))
			return 1'b1;
		for (int dr = -1; dr <= 1; dr++)
			for (int dc = -1; dc <= 1; dc++)
				if (!known[idx + dr * cur_w + dc])
					return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [7:0] cell_fill(input bit centre);
		int r;
		r = $urandom_range(0, 9);
		if (centre)
			return (r < 8) ? UNKNOWN_VALUE : 8'($urandom);
		if (r < 6)
			return FREE_VALUE;
		if (r < 8)
			return UNKNOWN_VALUE;
		if (r < 9)
			return MARK_VALUE;
		return 8'($urandom);
	endfunction

	task automatic send_word(input logic [1:0] op, input int idx, input logic [7:0] val);
		int gap;
		s_tuser <= op;
		s_tdata <= {val, 16'(idx)};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		if (op != OP_NOP)
			phase_items++;
		gap = pause_len();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic put_cell(input int idx, input logic [7:0] val);
		send_word(OP_WRITE, idx, val);
		if (!known[idx]) begin
			known[idx] = 1'b1;
			known_list.push_back(idx);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (words_owed != 0)
			@(posedge clk);
	endtask

	task automatic set_dims(input logic [8:0] wv, input logic [8:0] hv);
		cfg_we <= 1'b1;
		cfg_index <= REG_WIDTH;
		cfg_data <= wv;
		@(posedge clk);
		cfg_index <= REG_HEIGHT;
		cfg_data <= hv;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_w = (wv < 9'd3) ? 3 : (wv > 9'd256) ? 256 : int'(wv);
		cur_h = (hv < 9'd3) ? 3 : (hv > 9'd256) ? 256 : int'(hv);
	endtask

	// fill a 3x3 block around an interior cell, examine it, sometimes read a cell of the block back
	task automatic frontier_round();
		int c;
		int spot;
		c = $urandom_range(1, cur_h - 2) * cur_w + $urandom_range(1, cur_w - 2);
		for (int dr = -1; dr <= 1; dr++) begin
			for (int dc = -1; dc <= 1; dc++) begin
				spot = c + dr * cur_w + dc;
				if (!known[spot] || $urandom_range(0, 1) == 0)
					put_cell(spot, cell_fill(spot == c));
			end
		end
		send_word(OP_EXAMINE, c, 8'($urandom));
		if ($urandom_range(0, 2) == 0) begin
			spot = c - cur_w - 1 + $urandom_range(0, 2) * cur_w + $urandom_range(0, 2);
			send_word(OP_READ, spot, 8'($urandom));
		end
	endtask

	task automatic noise_word();
		int pick;
		int idx;
		pick = $urandom_range(0, 99);
		idx = known_list[$urandom_range(0, known_list.size() - 1)];
		if (pick < 30)
			put_cell($urandom_range(0, 65535), 8'($urandom));
		else if (pick < 55)
			send_word(OP_READ, idx, 8'($urandom));
		else if (pick < 70)
			send_word(OP_NOP, $urandom_range(0, 65535), 8'($urandom));
		else if (area_known(idx))
			send_word(OP_EXAMINE, idx, 8'($urandom));
		else
			send_word(OP_READ, idx, 8'($urandom));
	endtask

	task automatic run_phase(input logic [8:0] wv, input logic [8:0] hv, input int quota);
		set_dims(wv, hv);
		quiet = ($urandom_range(0, 3) == 0);
		phase_items = 0;
		while (phase_items < quota) begin
			if ($urandom_range(0, 99) < 65)
				frontier_round();
			else
				noise_word();
		end
		drain();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// field extremes at the reset size of 256 x 256
		put_cell(0, 8'h7F);
		put_cell(65535, 8'h80);
		send_word(OP_READ, 0, 8'h00);
		send_word(OP_READ, 65535, 8'hFF);
		send_word(OP_NOP, 65535, 8'hFF);

		// unknown cell with a fully free ring: every ring cell becomes an edge, in ring order
		for (int dr = -1; dr <= 1; dr++)
			for (int dc = -1; dc <= 1; dc++)
				put_cell(257 + dr * 256 + dc, (dr == 0 && dc == 0) ? UNKNOWN_VALUE : FREE_VALUE);
		send_word(OP_EXAMINE, 257, 8'h00);
		// ring now marked, so nothing new
		send_word(OP_EXAMINE, 257, 8'h00);
		send_word(OP_READ, 258, 8'h00);
		// border cells are never interior
		send_word(OP_EXAMINE, 0, 8'h00);
		send_word(OP_EXAMINE, 65535, 8'h00);
		// centre that is not unknown
		put_cell(257, FREE_VALUE);
		send_word(OP_EXAMINE, 257, 8'h00);
		drain();

		run_phase(9'd3, 9'd3, 60);
		run_phase(9'd0, 9'd2, 40);
		run_phase(9'd511, 9'd300, 60);
		run_phase(9'd5, 9'd7, 60);
		run_phase(9'd16, 9'd9, 60);
		run_phase(9'd256, 9'd3, 50);
		run_phase(9'($urandom_range(3, 40)), 9'($urandom_range(3, 40)), 60);
		run_phase(9'($urandom_range(3, 40)), 9'($urandom_range(3, 40)), 60);
		run_phase(9'd256, 9'd256, 40);

		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== files.f =====
design/fem_pkg.sv
design/fem_div.sv
design/fem_ram.sv
design/frontier_edge_marker.sv
test/edge_marker_checker.sv
test/tb.sv
